[rtl/core/i2crm_pkg.sv]
// Package for the I2C register master: word types, bus phase codes,
// command, stage and status codes, the half period clamp and the line-level decode function.
// Depends on nothing; used by every module of the block.
`default_nettype none

package i2crm_pkg;

    localparam int TIMER_W = 16;
    localparam int HALF_W = 16;
    localparam logic [63:0] TIMER_MAX = (64'd1 << TIMER_W) - 64'd1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [4:0] PH_IDLE = 5'd0;
    localparam logic [4:0] PH_ST_A = 5'd1;
    localparam logic [4:0] PH_ST_B = 5'd2;
    localparam logic [4:0] PH_ST_C = 5'd3;
    localparam logic [4:0] PH_RS_GAP = 5'd4;
    localparam logic [4:0] PH_BIT_LO = 5'd5;
    localparam logic [4:0] PH_BIT_HI = 5'd6;
    localparam logic [4:0] PH_ACK_LO = 5'd7;
    localparam logic [4:0] PH_ACK_HI = 5'd8;
    localparam logic [4:0] PH_ACK_END = 5'd9;
    localparam logic [4:0] PH_RX_GAP = 5'd10;
    localparam logic [4:0] PH_RX_HI = 5'd11;
    localparam logic [4:0] PH_RX_LO = 5'd12;
    localparam logic [4:0] PH_NK_A = 5'd13;
    localparam logic [4:0] PH_NK_B = 5'd14;
    localparam logic [4:0] PH_NK_C = 5'd15;
    localparam logic [4:0] PH_SP_A = 5'd16;
    localparam logic [4:0] PH_SP_B = 5'd17;
    localparam logic [4:0] PH_SP_C = 5'd18;

    localparam logic [1:0] STG_ADDR_W = 2'd0;
    localparam logic [1:0] STG_REG = 2'd1;
    localparam logic [1:0] STG_DATA = 2'd2;
    localparam logic [1:0] STG_ADDR_R = 2'd3;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_ADDR_NACK = 3'd1;
    localparam logic [2:0] ST_REG_NACK = 3'd2;
    localparam logic [2:0] ST_RADDR_NACK = 3'd3;
    localparam logic [2:0] ST_DATA_NACK = 3'd4;

    localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(3);
    localparam logic [2:0] BIT_TOP = 3'd7;

    localparam int REG_HALF = 0;

    typedef struct packed {
        logic [1:0] operation;
        logic [6:0] device_address;
        logic [7:0] register_address;
        logic [7:0] write_data;
        logic       sda_sample;
    } t_in_word;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_listening;
        logic       busy_res;
        logic       done_res;
        logic [2:0] status;
        logic [7:0] read_data;
        logic       command_ignored;
    } t_out_word;

    typedef struct packed {
        logic       begin_cmd;
        logic       rd;
        logic [6:0] device_address;
        logic [7:0] register_address;
        logic [7:0] write_data;
        logic       sda_sample;
    } t_item;

    typedef struct packed {
        logic scl;
        logic sda;
        logic listen;
    } t_levels;

    function automatic logic [TIMER_W-1:0] eff_half(input logic [HALF_W-1:0] h);
        logic [63:0] v;
        v = 64'(h);
        if (v == 64'd0) begin
            v = 64'd1;
        end
        if (v > TIMER_MAX) begin
            v = TIMER_MAX;
        end
        return v[TIMER_W-1:0];
    endfunction

    function automatic t_levels drive_levels(input logic [4:0] ph, input logic [7:0] sh,
                                             input logic [2:0] bi);
        t_levels l;
        logic b;
        b = sh[bi];
        l.listen = 1'b0;
        l.scl = 1'b1;
        l.sda = 1'b1;
        case (ph)
            PH_ST_A: begin
                l.scl = 1'b1; l.sda = 1'b1;
            end
            PH_ST_B, PH_SP_B: begin
                l.scl = 1'b1; l.sda = 1'b0;
            end
            PH_ST_C, PH_RS_GAP, PH_ACK_END, PH_SP_A: begin
                l.scl = 1'b0; l.sda = 1'b0;
            end
            PH_BIT_LO: begin
                l.scl = 1'b0; l.sda = b;
            end
            PH_BIT_HI: begin
                l.scl = 1'b1; l.sda = b;
            end
            PH_ACK_LO, PH_RX_GAP, PH_RX_LO: begin
                l.scl = 1'b0; l.sda = 1'b1; l.listen = 1'b1;
            end
            PH_ACK_HI, PH_RX_HI: begin
                l.scl = 1'b1; l.sda = 1'b1; l.listen = 1'b1;
            end
            PH_NK_A, PH_NK_C: begin
                l.scl = 1'b0; l.sda = 1'b1;
            end
            default: begin
                l.scl = 1'b1; l.sda = 1'b1;
            end
        endcase
        return l;
    endfunction

endpackage

`default_nettype wire

[rtl/core/i2crm_front.sv]
// Front end of the I2C register master: classifies each incoming word
// into a begin command or a plain tick. Depends on i2crm_pkg.
`default_nettype none

module i2crm_front (
    input  wire i2crm_pkg::t_in_word i_word,
    output i2crm_pkg::t_item         o_item
);

    always_comb begin
        o_item.begin_cmd = (i_word.operation == i2crm_pkg::OP_WRITE) ||
                           (i_word.operation == i2crm_pkg::OP_READ);
        o_item.rd = (i_word.operation == i2crm_pkg::OP_READ);
        o_item.device_address = i_word.device_address;
        o_item.register_address = i_word.register_address;
        o_item.write_data = i_word.write_data;
        o_item.sda_sample = i_word.sda_sample;
    end

endmodule

`default_nettype wire

[rtl/core/i2crm_queue.sv]
// Short register queue between the front end and the bus sequencer.
// Depends on i2crm_pkg for the item type and depth.
`default_nettype none

module i2crm_queue (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_push,
    input  wire i2crm_pkg::t_item  i_item,
    output logic                   o_full,
    input  wire                    i_pop,
    output logic                   o_empty,
    output i2crm_pkg::t_item       o_item
);

    i2crm_pkg::t_item r_mem [i2crm_pkg::QUEUE_DEPTH];
    logic [i2crm_pkg::QUEUE_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [i2crm_pkg::QUEUE_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [i2crm_pkg::QUEUE_CNT_W-1:0] r_count, n_count;
    logic do_push, do_pop;

    assign o_full = (r_count == i2crm_pkg::QUEUE_CNT_W'(i2crm_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop = i_pop && !o_empty;
    assign o_item = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= i2crm_pkg::QUEUE_CNT_W'(i2crm_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count missed a push");

endmodule

`default_nettype wire

[rtl/core/i2crm_back.sv]
// Bus sequencer of the I2C register master: runs the phase machine one
// item per cycle while the queue holds an item and the output is not stalled,
// and holds the result word in an output register. Depends on i2crm_pkg.
`default_nettype none

module i2crm_back (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire [i2crm_pkg::HALF_W-1:0]         i_half,
    input  wire                                 i_empty,
    input  wire i2crm_pkg::t_item               i_item,
    output logic                                o_pop,
    output logic                                o_valid,
    input  wire                                 i_stall,
    output i2crm_pkg::t_out_word                o_word
);

    logic [4:0] r_phase, n_phase;
    logic [2:0] r_bit, n_bit;
    logic [7:0] r_shift, n_shift;
    logic [i2crm_pkg::TIMER_W-1:0] r_timer, n_timer;
    logic [6:0] r_dev, n_dev;
    logic [7:0] r_regaddr, n_regaddr;
    logic [7:0] r_payload, n_payload;
    logic r_is_read, n_is_read;
    logic [1:0] r_stage, n_stage;
    logic [2:0] r_status, n_status;
    logic r_out_valid;
    i2crm_pkg::t_out_word r_out, n_out;
    logic [i2crm_pkg::TIMER_W-1:0] half_eff;
    logic [i2crm_pkg::TIMER_W:0] timer_inc;
    i2crm_pkg::t_levels lv;
    logic done, ignored;
    logic [2:0] res_status;
    logic [7:0] res_data;

    assign o_pop = !i_empty && (!r_out_valid || !i_stall);
    assign o_valid = r_out_valid;
    assign o_word = r_out;
    assign half_eff = i2crm_pkg::eff_half(i_half);
    assign timer_inc = {1'b0, r_timer} + 1'b1;

    always_comb begin
        n_phase = r_phase;
        n_bit = r_bit;
        n_shift = r_shift;
        n_timer = r_timer;
        n_dev = r_dev;
        n_regaddr = r_regaddr;
        n_payload = r_payload;
        n_is_read = r_is_read;
        n_stage = r_stage;
        n_status = r_status;
        done = 1'b0;
        ignored = 1'b0;
        res_status = i2crm_pkg::ST_OK;
        res_data = 8'd0;
        if (r_phase == i2crm_pkg::PH_IDLE) begin
            if (i_item.begin_cmd) begin
                n_dev = i_item.device_address;
                n_regaddr = i_item.register_address;
                n_payload = i_item.write_data;
                n_is_read = i_item.rd;
                n_stage = i2crm_pkg::STG_ADDR_W;
                n_status = i2crm_pkg::ST_OK;
                n_shift = {i_item.device_address, 1'b0};
                n_bit = i2crm_pkg::BIT_TOP;
                n_timer = '0;
                n_phase = i2crm_pkg::PH_ST_A;
            end
        end else begin
            ignored = i_item.begin_cmd;
            if (timer_inc < {1'b0, half_eff}) begin
                n_timer = timer_inc[i2crm_pkg::TIMER_W-1:0];
            end else begin
                n_timer = '0;
                case (r_phase)
                    i2crm_pkg::PH_ST_A: begin
                        n_phase = i2crm_pkg::PH_ST_B;
                    end
                    i2crm_pkg::PH_ST_B: begin
                        n_phase = i2crm_pkg::PH_ST_C;
                    end
                    i2crm_pkg::PH_ST_C: begin
                        n_phase = (r_stage == i2crm_pkg::STG_ADDR_R) ?
                                  i2crm_pkg::PH_RS_GAP : i2crm_pkg::PH_BIT_LO;
                    end
                    i2crm_pkg::PH_RS_GAP: begin
                        n_phase = i2crm_pkg::PH_BIT_LO;
                    end
                    i2crm_pkg::PH_BIT_LO: begin
                        n_phase = i2crm_pkg::PH_BIT_HI;
                    end
                    i2crm_pkg::PH_BIT_HI: begin
                        if (r_bit == 3'd0) begin
                            n_bit = i2crm_pkg::BIT_TOP;
                            n_phase = i2crm_pkg::PH_ACK_LO;
                        end else begin
                            n_bit = r_bit - 1'b1;
                            n_phase = i2crm_pkg::PH_BIT_LO;
                        end
                    end
                    i2crm_pkg::PH_ACK_LO: begin
                        n_phase = i2crm_pkg::PH_ACK_HI;
                    end
                    i2crm_pkg::PH_ACK_HI: begin
                        if (i_item.sda_sample) begin
                            case (r_stage)
                                i2crm_pkg::STG_ADDR_W: n_status = i2crm_pkg::ST_ADDR_NACK;
                                i2crm_pkg::STG_REG: n_status = i2crm_pkg::ST_REG_NACK;
                                i2crm_pkg::STG_DATA: n_status = i2crm_pkg::ST_DATA_NACK;
                                default: n_status = i2crm_pkg::ST_RADDR_NACK;
                            endcase
                        end
                        n_phase = i2crm_pkg::PH_ACK_END;
                    end
                    i2crm_pkg::PH_ACK_END: begin
                        if (r_status != i2crm_pkg::ST_OK) begin
                            n_phase = i2crm_pkg::PH_SP_A;
                        end else begin
                            case (r_stage)
                                i2crm_pkg::STG_ADDR_W: begin
                                    n_stage = i2crm_pkg::STG_REG;
                                    n_shift = r_regaddr;
                                    n_phase = i2crm_pkg::PH_BIT_LO;
                                end
                                i2crm_pkg::STG_REG: begin
                                    if (r_is_read) begin
                                        n_stage = i2crm_pkg::STG_ADDR_R;
                                        n_shift = {r_dev, 1'b1};
                                        n_phase = i2crm_pkg::PH_ST_A;
                                    end else begin
                                        n_stage = i2crm_pkg::STG_DATA;
                                        n_shift = r_payload;
                                        n_phase = i2crm_pkg::PH_BIT_LO;
                                    end
                                end
                                i2crm_pkg::STG_DATA: begin
                                    n_phase = i2crm_pkg::PH_SP_A;
                                end
                                default: begin
                                    n_shift = 8'd0;
                                    n_bit = i2crm_pkg::BIT_TOP;
                                    n_phase = i2crm_pkg::PH_RX_GAP;
                                end
                            endcase
                        end
                    end
                    i2crm_pkg::PH_RX_GAP: begin
                        n_phase = i2crm_pkg::PH_RX_HI;
                    end
                    i2crm_pkg::PH_RX_HI: begin
                        if (i_item.sda_sample) begin
                            n_shift[r_bit] = 1'b1;
                        end
                        n_phase = i2crm_pkg::PH_RX_LO;
                    end
                    i2crm_pkg::PH_RX_LO: begin
                        if (r_bit == 3'd0) begin
                            n_bit = i2crm_pkg::BIT_TOP;
                            n_phase = i2crm_pkg::PH_NK_A;
                        end else begin
                            n_bit = r_bit - 1'b1;
                            n_phase = i2crm_pkg::PH_RX_HI;
                        end
                    end
                    i2crm_pkg::PH_NK_A: begin
                        n_phase = i2crm_pkg::PH_NK_B;
                    end
                    i2crm_pkg::PH_NK_B: begin
                        n_phase = i2crm_pkg::PH_NK_C;
                    end
                    i2crm_pkg::PH_NK_C: begin
                        n_phase = i2crm_pkg::PH_SP_A;
                    end
                    i2crm_pkg::PH_SP_A: begin
                        n_phase = i2crm_pkg::PH_SP_B;
                    end
                    i2crm_pkg::PH_SP_B: begin
                        n_phase = i2crm_pkg::PH_SP_C;
                    end
                    i2crm_pkg::PH_SP_C: begin
                        n_phase = i2crm_pkg::PH_IDLE;
                        done = 1'b1;
                        res_status = r_status;
                        res_data = (r_is_read && (r_status == i2crm_pkg::ST_OK)) ?
                                   r_shift : 8'd0;
                    end
                    default: begin
                        n_phase = i2crm_pkg::PH_IDLE;
                    end
                endcase
            end
        end
        lv = i2crm_pkg::drive_levels(n_phase, n_shift, n_bit);
        n_out.scl_level = lv.scl;
        n_out.sda_level = lv.sda;
        n_out.sda_listening = lv.listen;
        n_out.busy_res = (n_phase != i2crm_pkg::PH_IDLE);
        n_out.done_res = done;
        n_out.status = res_status;
        n_out.read_data = res_data;
        n_out.command_ignored = ignored;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= i2crm_pkg::PH_IDLE;
            r_bit <= i2crm_pkg::BIT_TOP;
            r_shift <= 8'd0;
            r_timer <= '0;
            r_dev <= 7'd0;
            r_regaddr <= 8'd0;
            r_payload <= 8'd0;
            r_is_read <= 1'b0;
            r_stage <= i2crm_pkg::STG_ADDR_W;
            r_status <= i2crm_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase <= n_phase;
                r_bit <= n_bit;
                r_shift <= n_shift;
                r_timer <= n_timer;
                r_dev <= n_dev;
                r_regaddr <= n_regaddr;
                r_payload <= n_payload;
                r_is_read <= n_is_read;
                r_stage <= n_stage;
                r_status <= n_status;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done_res) |-> !r_out.busy_res)
        else $error("done word still shows busy");

    a_status_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status != i2crm_pkg::ST_OK)) |-> r_out.done_res)
        else $error("error status outside a done word");

    a_data_on_ok_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.read_data != 8'd0)) |->
        (r_out.done_res && (r_out.status == i2crm_pkg::ST_OK)))
        else $error("read data outside a successful done word");

    a_idle_bus_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.busy_res) |-> (r_out.scl_level && r_out.sda_level))
        else $error("bus not released while idle");

endmodule

`default_nettype wire

[rtl/core/i2c_register_master.sv]
// Top level of the I2C register master: configuration port, front end,
// queue and bus sequencer. Depends on i2crm_pkg, i2crm_front,
// i2crm_queue and i2crm_back.
//
//   channel   direction  handshake                   word
//   in        input      i_in_valid / o_in_stall     i2crm_pkg::t_in_word
//   out       output     o_out_valid / i_out_stall   i2crm_pkg::t_out_word
//   config    input      psel/penable/pwrite/pready  half_period_ticks at 0x0
//
// A word is accepted every cycle while the four-entry queue has room. The
// result word is loaded into the output register at the edge at which its
// word leaves the queue, so even with an empty queue and a free output a
// word passes through a queue entry and then the output register. The phase
// timer, not the clock, sets the bus timing. Reset is synchronous and
// empties the queue, the output register and the sequencer, and restores
// a half period of 3.
// An output stall holds the result register and lets the queue fill, after
// which o_in_stall rises.
`default_nettype none

module i2c_register_master (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_in_valid,
    output logic                       o_in_stall,
    input  wire i2crm_pkg::t_in_word   i_in_word,
    output logic                       o_out_valid,
    input  wire                        i_out_stall,
    output i2crm_pkg::t_out_word       o_out_word,
    input  wire                        psel,
    input  wire                        penable,
    input  wire                        pwrite,
    input  wire [2:0]                  paddr,
    input  wire [31:0]                 pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic [i2crm_pkg::HALF_W-1:0] r_half;
    i2crm_pkg::t_item front_item;
    i2crm_pkg::t_item queue_item;
    logic queue_full, queue_empty, queue_pop;
    logic cfg_write;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[2] == 1'(i2crm_pkg::REG_HALF));
    assign prdata = (paddr[2] == 1'(i2crm_pkg::REG_HALF)) ? 32'(r_half) : 32'd0;
    assign o_in_stall = queue_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= i2crm_pkg::HALF_RESET;
        end else if (cfg_write) begin
            r_half <= pwdata[i2crm_pkg::HALF_W-1:0];
        end
    end

    i2crm_front u_front (
        .i_word (i_in_word),
        .o_item (front_item)
    );

    i2crm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_item  (front_item),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_empty (queue_empty),
        .o_item  (queue_item)
    );

    i2crm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_half  (r_half),
        .i_empty (queue_empty),
        .i_item  (queue_item),
        .o_pop   (queue_pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_word  (o_out_word)
    );

endmodule

`default_nettype wire

[dv/i2crm_bus_checker.sv]
`timescale 1ns / 100ps
// Result checker for the I2C register master: predicts every result word from the
// accepted input words and the half period register, then compares in order.
// Depends on i2crm_pkg for the word types and the phase, stage and status codes.

module i2crm_bus_checker (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_in_valid,
    input  wire                       i_in_stall,
    input  wire i2crm_pkg::t_in_word  i_in_word,
    input  wire                       i_out_valid,
    input  wire                       i_out_stall,
    input  wire i2crm_pkg::t_out_word i_out_word,
    input  wire                       i_psel,
    input  wire                       i_penable,
    input  wire                       i_pwrite,
    input  wire [2:0]                 i_paddr,
    input  wire [31:0]                i_pwdata,
    input  wire                       i_pready,
    output int                        o_fail_count,
    output int                        o_pending
);

    logic [i2crm_pkg::HALF_W-1:0]  half_ticks;
    logic [4:0]                    phase;
    logic [2:0]                    bit_idx;
    logic [7:0]                    shreg;
    logic [i2crm_pkg::TIMER_W-1:0] timer;
    logic [6:0]                    dev_hold;
    logic [7:0]                    reg_hold;
    logic [7:0]                    data_hold;
    logic                          rd_hold;
    logic [1:0]                    stage;
    logic [2:0]                    err;
    i2crm_pkg::t_out_word          fresh;
    i2crm_pkg::t_out_word          oldest;
    i2crm_pkg::t_out_word          predicted_words[$];
    int                            mismatches = 0;

    assign o_fail_count = mismatches;

    task automatic report(input string field, input logic [7:0] got, input logic [7:0] want);
        mismatches++;
        $display("%0t: %s mismatch, got %0h, expected %0h", $time, field, got, want);
    endtask

    task automatic reset_bus();
        half_ticks = i2crm_pkg::HALF_RESET;
        phase = i2crm_pkg::PH_IDLE;
        bit_idx = i2crm_pkg::BIT_TOP;
        shreg = '0;
        timer = '0;
        dev_hold = '0;
        reg_hold = '0;
        data_hold = '0;
        rd_hold = 1'b0;
        stage = i2crm_pkg::STG_ADDR_W;
        err = i2crm_pkg::ST_OK;
    endtask

    // Moves the sequencer out of a phase whose time has run out.
    task automatic close_phase(input logic sda_bit);
        case (phase)
            i2crm_pkg::PH_ST_A: phase = i2crm_pkg::PH_ST_B;
            i2crm_pkg::PH_ST_B: phase = i2crm_pkg::PH_ST_C;
            i2crm_pkg::PH_ST_C: phase = (stage == i2crm_pkg::STG_ADDR_R) ?
                                        i2crm_pkg::PH_RS_GAP : i2crm_pkg::PH_BIT_LO;
            i2crm_pkg::PH_RS_GAP: phase = i2crm_pkg::PH_BIT_LO;
            i2crm_pkg::PH_BIT_LO: phase = i2crm_pkg::PH_BIT_HI;
            i2crm_pkg::PH_BIT_HI: begin
                if (bit_idx == 3'd0) begin
                    bit_idx = i2crm_pkg::BIT_TOP;
                    phase = i2crm_pkg::PH_ACK_LO;
                end else begin
                    bit_idx = bit_idx - 3'd1;
                    phase = i2crm_pkg::PH_BIT_LO;
                end
            end
            i2crm_pkg::PH_ACK_LO: phase = i2crm_pkg::PH_ACK_HI;
            i2crm_pkg::PH_ACK_HI: begin
                if (sda_bit) begin
                    case (stage)
                        i2crm_pkg::STG_ADDR_W: err = i2crm_pkg::ST_ADDR_NACK;
                        i2crm_pkg::STG_REG: err = i2crm_pkg::ST_REG_NACK;
                        i2crm_pkg::STG_DATA: err = i2crm_pkg::ST_DATA_NACK;
                        default: err = i2crm_pkg::ST_RADDR_NACK;
                    endcase
                end
                phase = i2crm_pkg::PH_ACK_END;
            end
            i2crm_pkg::PH_ACK_END: begin
                if (err != i2crm_pkg::ST_OK) begin
                    phase = i2crm_pkg::PH_SP_A;
                end else if (stage == i2crm_pkg::STG_ADDR_W) begin
                    stage = i2crm_pkg::STG_REG;
                    shreg = reg_hold;
                    phase = i2crm_pkg::PH_BIT_LO;
                end else if (stage == i2crm_pkg::STG_REG) begin
                    if (rd_hold) begin
                        stage = i2crm_pkg::STG_ADDR_R;
                        shreg = {dev_hold, 1'b1};
                        phase = i2crm_pkg::PH_ST_A;
                    end else begin
                        stage = i2crm_pkg::STG_DATA;
                        shreg = data_hold;
                        phase = i2crm_pkg::PH_BIT_LO;
                    end
                end else if (stage == i2crm_pkg::STG_DATA) begin
                    phase = i2crm_pkg::PH_SP_A;
                end else begin
                    shreg = '0;
                    bit_idx = i2crm_pkg::BIT_TOP;
                    phase = i2crm_pkg::PH_RX_GAP;
                end
            end
            i2crm_pkg::PH_RX_GAP: phase = i2crm_pkg::PH_RX_HI;
            i2crm_pkg::PH_RX_HI: begin
                if (sda_bit) begin
                    shreg[bit_idx] = 1'b1;
                end
                phase = i2crm_pkg::PH_RX_LO;
            end
            i2crm_pkg::PH_RX_LO: begin
                if (bit_idx == 3'd0) begin
                    bit_idx = i2crm_pkg::BIT_TOP;
                    phase = i2crm_pkg::PH_NK_A;
                end else begin
                    bit_idx = bit_idx - 3'd1;
                    phase = i2crm_pkg::PH_RX_HI;
                end
            end
            i2crm_pkg::PH_NK_A: phase = i2crm_pkg::PH_NK_B;
            i2crm_pkg::PH_NK_B: phase = i2crm_pkg::PH_NK_C;
            i2crm_pkg::PH_NK_C: phase = i2crm_pkg::PH_SP_A;
            i2crm_pkg::PH_SP_A: phase = i2crm_pkg::PH_SP_B;
            i2crm_pkg::PH_SP_B: phase = i2crm_pkg::PH_SP_C;
            i2crm_pkg::PH_SP_C: begin
                phase = i2crm_pkg::PH_IDLE;
                fresh.done_res = 1'b1;
                fresh.status = err;
                fresh.read_data = (rd_hold && err == i2crm_pkg::ST_OK) ? shreg : 8'h00;
            end
            default: phase = i2crm_pkg::PH_IDLE;
        endcase
    endtask

    // Clock, data and listen levels of the current phase.
    function automatic logic [2:0] line_levels();
        logic b;
        b = shreg[bit_idx];
        case (phase)
            i2crm_pkg::PH_ST_A: return 3'b110;
            i2crm_pkg::PH_ST_B, i2crm_pkg::PH_SP_B: return 3'b100;
            i2crm_pkg::PH_ST_C, i2crm_pkg::PH_RS_GAP, i2crm_pkg::PH_ACK_END,
            i2crm_pkg::PH_SP_A: return 3'b000;
            i2crm_pkg::PH_BIT_LO: return {1'b0, b, 1'b0};
            i2crm_pkg::PH_BIT_HI: return {1'b1, b, 1'b0};
            i2crm_pkg::PH_ACK_LO, i2crm_pkg::PH_RX_GAP, i2crm_pkg::PH_RX_LO: return 3'b011;
            i2crm_pkg::PH_ACK_HI, i2crm_pkg::PH_RX_HI: return 3'b111;
            i2crm_pkg::PH_NK_A, i2crm_pkg::PH_NK_C: return 3'b010;
            default: return 3'b110;
        endcase
    endfunction

    task automatic advance_bus(input i2crm_pkg::t_in_word w);
        logic [16:0] hper;
        logic        begin_cmd;
        hper = (half_ticks == '0) ? 17'd1 : 17'(half_ticks);
        if (64'(hper) > i2crm_pkg::TIMER_MAX) begin
            hper = 17'(i2crm_pkg::TIMER_MAX);
        end
        begin_cmd = (w.operation == i2crm_pkg::OP_WRITE) ||
                    (w.operation == i2crm_pkg::OP_READ);
        fresh = '0;
        if (phase == i2crm_pkg::PH_IDLE) begin
            if (begin_cmd) begin
                dev_hold = w.device_address;
                reg_hold = w.register_address;
                data_hold = w.write_data;
                rd_hold = (w.operation == i2crm_pkg::OP_READ);
                stage = i2crm_pkg::STG_ADDR_W;
                err = i2crm_pkg::ST_OK;
                shreg = {w.device_address, 1'b0};
                bit_idx = i2crm_pkg::BIT_TOP;
                timer = '0;
                phase = i2crm_pkg::PH_ST_A;
            end
        end else begin
            fresh.command_ignored = begin_cmd;
            if (17'(timer) + 17'd1 < hper) begin
                timer = timer + 1'b1;
            end else begin
                timer = '0;
                close_phase(w.sda_sample);
            end
        end
        {fresh.scl_level, fresh.sda_level, fresh.sda_listening} = line_levels();
        fresh.busy_res = (phase != i2crm_pkg::PH_IDLE);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_bus();
            predicted_words.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (predicted_words.size() == 0) begin
                    report("unexpected word, read_data", i_out_word.read_data, 8'h00);
                end else begin
                    oldest = predicted_words.pop_front();
                    if (i_out_word.scl_level !== oldest.scl_level)
                        report("scl_level", 8'(i_out_word.scl_level), 8'(oldest.scl_level));
                    if (i_out_word.sda_level !== oldest.sda_level)
                        report("sda_level", 8'(i_out_word.sda_level), 8'(oldest.sda_level));
                    if (i_out_word.sda_listening !== oldest.sda_listening)
                        report("sda_listening", 8'(i_out_word.sda_listening),
                               8'(oldest.sda_listening));
                    if (i_out_word.busy_res !== oldest.busy_res)
                        report("busy_res", 8'(i_out_word.busy_res), 8'(oldest.busy_res));
                    if (i_out_word.done_res !== oldest.done_res)
                        report("done_res", 8'(i_out_word.done_res), 8'(oldest.done_res));
                    if (i_out_word.status !== oldest.status)
                        report("status", 8'(i_out_word.status), 8'(oldest.status));
                    if (i_out_word.read_data !== oldest.read_data)
                        report("read_data", i_out_word.read_data, oldest.read_data);
                    if (i_out_word.command_ignored !== oldest.command_ignored)
                        report("command_ignored", 8'(i_out_word.command_ignored),
                               8'(oldest.command_ignored));
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr == 3'(i2crm_pkg::REG_HALF * 4)) begin
                half_ticks = i_pwdata[i2crm_pkg::HALF_W-1:0];
            end
            if (i_in_valid && !i_in_stall) begin
                advance_bus(i_in_word);
                predicted_words.push_back(fresh);
            end
        end
        o_pending <= predicted_words.size();
    end

endmodule

[dv/i2c_register_master_tb.sv]
`timescale 1ns / 100ps
// Top of the I2C register master testbench: clock, reset, command and tick
// stimulus, output stalls, register writes, watchdog and the final verdict.
// Depends on i2crm_pkg, i2c_register_master and i2crm_bus_checker.

module i2c_register_master_tb;

    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int ACK_ALL = 0;
    localparam int NACK_ADDR = 1;
    localparam int NACK_REG = 2;
    localparam int NACK_LAST = 3;
    localparam int FILL_RANDOM = 0;
    localparam int FILL_ONES = 1;
    localparam int FILL_ZEROS = 2;
    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    i2crm_pkg::t_in_word  i_in_word = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    i2crm_pkg::t_out_word o_out_word;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [2:0]           paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    int   fail_count;
    int   pending;
    int   words_sent = 0;
    int   half_now = 3;
    int   idle_cycles = 0;
    bit   calm = 1'b0;
    bit   hold_req = 1'b0;
    bit   hold_served = 1'b0;

    always #10 i_clk = ~i_clk;

    i2c_register_master dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    i2crm_bus_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_word    (i_in_word),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_word   (o_out_word),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Output stalls: quiet runs, random stalls, held stalls and one long hold-off.
    initial begin
        int n;
        int mode;
        forever begin
            if (hold_req && !hold_served) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_served = 1'b1;
            end else begin
                n = $urandom_range(1, 40);
                mode = $urandom_range(0, 9);
                repeat (n) begin
                    if (mode < 4) begin
                        i_out_stall <= 1'b0;
                    end else if (mode < 8) begin
                        i_out_stall <= ($urandom_range(0, 99) < 30);
                    end else if (mode == 8) begin
                        i_out_stall <= 1'b1;
                    end else begin
                        i_out_stall <= ($urandom_range(0, 99) < 80);
                    end
                    @(posedge i_clk);
                end
            end
        end
    end

    task automatic send_word(input i2crm_pkg::t_in_word w);
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (calm || r < 60) begin
            gap = 0;
        end else if (r < 90) begin
            gap = $urandom_range(1, 3);
        end else if (r < 98) begin
            gap = $urandom_range(4, 12);
        end else begin
            gap = $urandom_range(20, 60);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (o_in_stall);
        words_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic apb_write(input logic [15:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(i2crm_pkg::REG_HALF * 4);
        pwdata <= {16'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        half_now = int'(value);
    endtask

    task automatic idle_items(input int n);
        i2crm_pkg::t_in_word w;
        repeat (n) begin
            w = i2crm_pkg::t_in_word'($urandom);
            w.operation = $urandom_range(0, 1) ? OP_SPARE : i2crm_pkg::OP_TICK;
            send_word(w);
        end
    endtask

    // One command followed by exactly the ticks it takes to finish. The target's
    // answer is placed on the ticks that end each ACK clock; every other tick
    // carries the fill pattern, which also supplies the received data bits.
    task automatic run_txn(input logic [1:0] op, input logic [6:0] dev, input logic [7:0] ra,
                           input logic [7:0] wd, input int nack_at, input int fill,
                           input int noise_pct);
        i2crm_pkg::t_in_word w;
        int h;
        int len;
        int pos_addr;
        int pos_reg;
        int pos_last;
        h = (half_now == 0) ? 1 : half_now;
        pos_addr = 21 * h;
        pos_reg = 40 * h;
        pos_last = (op == i2crm_pkg::OP_READ) ? 63 * h : 59 * h;
        case (nack_at)
            NACK_ADDR: len = pos_addr + 4 * h;
            NACK_REG: len = pos_reg + 4 * h;
            NACK_LAST: len = pos_last + 4 * h;
            default: len = (op == i2crm_pkg::OP_READ) ? 87 * h : 63 * h;
        endcase
        calm = ($urandom_range(0, 3) == 0);
        w.operation = op;
        w.device_address = dev;
        w.register_address = ra;
        w.write_data = wd;
        w.sda_sample = 1'($urandom);
        send_word(w);
        for (int i = 1; i <= len; i++) begin
            w = i2crm_pkg::t_in_word'($urandom);
            w.operation = ($urandom_range(0, 99) < noise_pct) ? 2'($urandom_range(1, 3))
                                                                : i2crm_pkg::OP_TICK;
            case (fill)
                FILL_ONES: w.sda_sample = 1'b1;
                FILL_ZEROS: w.sda_sample = 1'b0;
                default: w.sda_sample = 1'($urandom);
            endcase
            if (i == pos_addr) begin
                w.sda_sample = (nack_at == NACK_ADDR);
            end else if (i == pos_reg) begin
                w.sda_sample = (nack_at == NACK_REG);
            end else if (i == pos_last) begin
                w.sda_sample = (nack_at == NACK_LAST);
            end
            send_word(w);
        end
        calm = 1'b0;
    endtask

    task automatic random_segment(input int budget);
        int start;
        int r;
        int nack_at;
        int fill;
        start = words_sent;
        while (words_sent - start < budget) begin
            r = $urandom_range(0, 99);
            nack_at = (r < 70) ? ACK_ALL : $urandom_range(NACK_ADDR, NACK_LAST);
            r = $urandom_range(0, 9);
            fill = (r == 0) ? FILL_ONES : (r == 1) ? FILL_ZEROS : FILL_RANDOM;
            run_txn($urandom_range(0, 1) ? i2crm_pkg::OP_READ : i2crm_pkg::OP_WRITE,
                    7'($urandom), 8'($urandom), 8'($urandom),
                    nack_at, fill, ($urandom_range(0, 4) == 0) ? 10 : 0);
            if ($urandom_range(0, 3) == 0) begin
                idle_items($urandom_range(1, 6));
            end
            if ($urandom_range(0, 9) == 0) begin
                drain();
            end
        end
    endtask

    initial begin
        logic [15:0] seg_half[4];
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset half period, then with a zero half period.
        run_txn(i2crm_pkg::OP_WRITE, 7'h7F, 8'hFF, 8'hFF, NACK_REG, FILL_ONES, 0);
        idle_items(4);
        drain();
        apb_write(16'd0);
        run_txn(i2crm_pkg::OP_WRITE, 7'h00, 8'h00, 8'h00, ACK_ALL, FILL_ZEROS, 0);
        run_txn(i2crm_pkg::OP_READ, 7'h7F, 8'hFF, 8'h5A, ACK_ALL, FILL_ONES, 0);
        run_txn(i2crm_pkg::OP_WRITE, 7'h55, 8'h0F, 8'hF0, NACK_ADDR, FILL_RANDOM, 0);
        run_txn(i2crm_pkg::OP_WRITE, 7'h2A, 8'hA5, 8'h3C, NACK_REG, FILL_RANDOM, 0);
        run_txn(i2crm_pkg::OP_WRITE, 7'h13, 8'h81, 8'h7E, NACK_LAST, FILL_RANDOM, 0);
        run_txn(i2crm_pkg::OP_READ, 7'h4C, 8'h24, 8'h00, NACK_LAST, FILL_RANDOM, 0);
        run_txn(i2crm_pkg::OP_WRITE, 7'h33, 8'h66, 8'hCC, ACK_ALL, FILL_RANDOM, 40);
        drain();

        // Widest half period: only idle words, since a transfer would run far too long.
        apb_write(16'hFFFF);
        idle_items(10);
        drain();

        seg_half[0] = 16'd1;
        seg_half[1] = 16'd2;
        seg_half[2] = 16'd1;
        seg_half[3] = 16'($urandom_range(1, 2));
        for (int s = 0; s < 4; s++) begin
            apb_write(seg_half[s]);
            if (s == 1) begin
                hold_req = 1'b1;
            end
            random_segment(30);
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[i2c_register_master.f]
rtl/core/i2crm_pkg.sv
rtl/core/i2crm_front.sv
rtl/core/i2crm_queue.sv
rtl/core/i2crm_back.sv
rtl/core/i2c_register_master.sv
dv/i2crm_bus_checker.sv
dv/i2c_register_master_tb.sv
